FILE: hw/rtl/hidt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hidt_pkg;

    // Fixed field widths
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 12;
    localparam int INDEX_W  = 7;
    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int SLOT_W   = 6;
    localparam int ENTRY_W  = HANDLE_W + 2 * LEN_W;
    // name + value + overhead: 4095 + 4095 + 32 fits in 14 bits
    localparam int SIZE_W   = 14;
    // table bytes never exceed limit + one entry
    localparam int BYTES_W  = 17;

    localparam int STATIC_COUNT   = 61;
    localparam int ENTRY_OVERHEAD = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_STATIC_HIT = 2'd1;
    localparam logic [1:0] STATUS_DYN_HIT    = 2'd2;
    localparam logic [1:0] STATUS_MISS       = 2'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [HANDLE_W-1:0] entry_handle;
        logic [LEN_W-1:0]    name_len;
        logic [LEN_W-1:0]    value_len;
        logic [INDEX_W-1:0]  lookup_index;
        logic [LIMIT_W-1:0]  new_limit;
    } req_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SLOT_W-1:0]   static_slot;
        logic [HANDLE_W-1:0] found_handle;
        logic [LEN_W-1:0]    found_name_len;
        logic [LEN_W-1:0]    found_value_len;
        logic [LIMIT_W-1:0]  bytes_in_use;
        logic [COUNT_W-1:0]  entries_in_use;
        logic [COUNT_W-1:0]  evicted_count;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FULL_DROP,
        S_ADD_WRITE,
        S_EVICT_CHECK,
        S_EVICT_DROP,
        S_LOOK_WAIT,
        S_DONE
    } hidt_state_t;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic rd_oldest;
        logic rd_lookup;
        logic drop;
        logic add_write;
        logic set_limit;
        logic capture_hit;
        logic finish;
    } hidt_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       too_big;
        logic       ring_full;
        logic       dyn_hit;
        logic       evict_needed;
        logic       out_free;
    } hidt_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hidt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hidt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hidt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hidt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire hidt_pkg::hidt_stat_t stat,
    output hidt_pkg::hidt_cmd_t      cmd
);

    import hidt_pkg::*;

    hidt_state_t state_reg;
    hidt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.func)
                    FUNC_ADD:
                    begin
                        if (stat.too_big)
                        begin
                            cmd.clear_all = 1'b1;
                            state_next    = S_DONE;
                        end
                        else if (stat.ring_full)
                        begin
                            cmd.rd_oldest = 1'b1;
                            state_next    = S_FULL_DROP;
                        end
                        else
                        begin
                            cmd.add_write = 1'b1;
                            state_next    = S_EVICT_CHECK;
                        end
                    end
                    FUNC_LOOKUP:
                    begin
                        if (stat.dyn_hit)
                        begin
                            cmd.rd_lookup = 1'b1;
                            state_next    = S_LOOK_WAIT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_RESIZE:
                    begin
                        cmd.set_limit = 1'b1;
                        state_next    = S_EVICT_CHECK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FULL_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_ADD_WRITE;
            end
            S_ADD_WRITE:
            begin
                cmd.add_write = 1'b1;
                state_next    = S_EVICT_CHECK;
            end
            S_EVICT_CHECK:
            begin
                if (stat.evict_needed)
                begin
                    cmd.rd_oldest = 1'b1;
                    state_next    = S_EVICT_DROP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EVICT_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_EVICT_CHECK;
            end
            S_LOOK_WAIT:
            begin
                cmd.capture_hit = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hidt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module hidt_dpath #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hidt_pkg::req_item_t  req,
    input  wire hidt_pkg::hidt_cmd_t  cmd,
    output hidt_pkg::hidt_stat_t      stat,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output hidt_pkg::rsp_item_t       rsp
);

    import hidt_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int KW = (CW > INDEX_W) ? CW : INDEX_W;

    // (ptr + n) mod depth, with ptr < depth and n <= depth
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr,
                                               input logic [CW-1:0] n);
        logic [CW:0] sum;
        sum = (CW+1)'(ptr) + (CW+1)'(n);
        if (sum >= (CW+1)'(RING_DEPTH))
        begin
            sum = sum - (CW+1)'(RING_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    req_item_t            item_reg;
    logic [PW-1:0]        oldest_reg,  oldest_next;
    logic [CW-1:0]        count_reg,   count_next;
    logic [BYTES_W-1:0]   bytes_reg,   bytes_next;
    logic [LIMIT_W-1:0]   limit_reg,   limit_next;
    logic [COUNT_W-1:0]   evicted_reg, evicted_next;
    logic [HANDLE_W-1:0]  fh_reg,      fh_next;
    logic [LEN_W-1:0]     fn_reg,      fn_next;
    logic [LEN_W-1:0]     fv_reg,      fv_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_reg,     rsp_next;

    logic [SIZE_W-1:0]    new_size;
    logic [SIZE_W-1:0]    old_size;
    logic [BYTES_W-1:0]   bytes_after_drop;
    logic                 static_hit;
    logic [INDEX_W-1:0]   dyn_k;
    logic [KW-1:0]        look_off;
    logic [PW-1:0]        wr_addr;
    logic [PW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic [ENTRY_W-1:0]   wr_data;
    logic [1:0]           result_status;

    hidt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.add_write),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_oldest | cmd.rd_lookup),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        new_size = SIZE_W'(item_reg.name_len) + SIZE_W'(item_reg.value_len)
                 + SIZE_W'(ENTRY_OVERHEAD);
        old_size = SIZE_W'(rd_data[2*LEN_W-1:LEN_W]) + SIZE_W'(rd_data[LEN_W-1:0])
                 + SIZE_W'(ENTRY_OVERHEAD);
        bytes_after_drop = (BYTES_W'(old_size) <= bytes_reg)
                         ? bytes_reg - BYTES_W'(old_size) : '0;

        static_hit = (item_reg.lookup_index != '0)
                  && (item_reg.lookup_index <= INDEX_W'(STATIC_COUNT));
        dyn_k      = item_reg.lookup_index - INDEX_W'(STATIC_COUNT);
        // distance from oldest: count - (index - static count)
        look_off   = KW'(count_reg) - KW'(dyn_k);

        wr_addr = wrap_add(oldest_reg, count_reg);
        wr_data = {item_reg.entry_handle, item_reg.name_len, item_reg.value_len};
        rd_addr = cmd.rd_lookup ? wrap_add(oldest_reg, CW'(look_off)) : oldest_reg;

        stat.func         = item_reg.func;
        stat.too_big      = LIMIT_W'(new_size) > limit_reg;
        stat.ring_full    = count_reg == CW'(RING_DEPTH);
        stat.dyn_hit      = (item_reg.lookup_index > INDEX_W'(STATIC_COUNT))
                         && (KW'(dyn_k) <= KW'(count_reg));
        stat.evict_needed = (count_reg != '0) && (bytes_reg > BYTES_W'(limit_reg));
        stat.out_free     = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        unique case (item_reg.func)
            FUNC_ADD:    result_status = STATUS_DONE;
            FUNC_RESIZE: result_status = STATUS_DONE;
            FUNC_LOOKUP:
            begin
                if (static_hit)
                begin
                    result_status = STATUS_STATIC_HIT;
                end
                else if (stat.dyn_hit)
                begin
                    result_status = STATUS_DYN_HIT;
                end
                else
                begin
                    result_status = STATUS_MISS;
                end
            end
            default:     result_status = STATUS_MISS;
        endcase
    end

    always_comb
    begin
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        limit_next     = limit_reg;
        evicted_next   = evicted_reg;
        fh_next        = fh_reg;
        fn_next        = fn_reg;
        fv_next        = fv_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (cmd.load)
        begin
            evicted_next = '0;
            fh_next      = '0;
            fn_next      = '0;
            fv_next      = '0;
        end
        if (cmd.clear_all)
        begin
            evicted_next = COUNT_W'(count_reg);
            oldest_next  = wrap_add(oldest_reg, count_reg);
            count_next   = '0;
            bytes_next   = '0;
        end
        if (cmd.drop)
        begin
            bytes_next   = bytes_after_drop;
            oldest_next  = (oldest_reg == PW'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
            count_next   = count_reg - 1'b1;
            evicted_next = evicted_reg + 1'b1;
        end
        if (cmd.add_write)
        begin
            count_next = count_reg + 1'b1;
            bytes_next = bytes_reg + BYTES_W'(new_size);
        end
        if (cmd.set_limit)
        begin
            limit_next = item_reg.new_limit;
        end
        if (cmd.capture_hit)
        begin
            fh_next = rd_data[ENTRY_W-1:2*LEN_W];
            fn_next = rd_data[2*LEN_W-1:LEN_W];
            fv_next = rd_data[LEN_W-1:0];
        end

        if (cmd.finish)
        begin
            rsp_valid_next           = 1'b1;
            rsp_next.status          = result_status;
            rsp_next.static_slot     = (item_reg.func == FUNC_LOOKUP && static_hit)
                                     ? item_reg.lookup_index[SLOT_W-1:0] : '0;
            rsp_next.found_handle    = fh_reg;
            rsp_next.found_name_len  = fn_reg;
            rsp_next.found_value_len = fv_reg;
            rsp_next.bytes_in_use    = bytes_reg[LIMIT_W-1:0];
            rsp_next.entries_in_use  = COUNT_W'(count_reg);
            rsp_next.evicted_count   = evicted_reg;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg    <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        evicted_reg <= evicted_next;
        fh_reg      <= fh_next;
        fn_reg      <= fn_next;
        fv_reg      <= fv_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/header_index_dynamic_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Header-compression dynamic table: a ring of RING_DEPTH entries (handle, name
// length, value length) with byte accounting, add, resize and indexed lookup.
// One item is worked at a time; the next item is taken while the previous
// result still waits in the output register. Static lookups, misses and
// oversized adds do not read the ring; a dynamic lookup reads it once; an
// add or resize evicts the oldest entries while the bytes exceed the limit,
// and an add on a full ring first drops the oldest. Each eviction costs a
// read of the ring through its single registered read port and a subtract.
// The ring needs no clearing after reset; items are taken right after it.
module header_index_dynamic_table_core #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire hidt_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output hidt_pkg::rsp_item_t      rsp
);

    import hidt_pkg::*;

    hidt_cmd_t  cmd;
    hidt_stat_t stat;

    hidt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hidt_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: sim/header_index_dynamic_table_core_tb.sv
`timescale 1ns / 1ps

module header_index_dynamic_table_core_tb;
    import hidt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int ITEM_TARGET  = 1150;
    localparam int CYCLE_LIMIT  = 600000;
    // slowest item: full ring on add, one drop, then up to 63 evictions
    localparam int DRAIN_CYCLES = 200;
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    typedef enum int {GEN_FILL, GEN_CHURN, GEN_NOISE} gen_flavor_t;

    typedef struct {
        req_item_t item;
        bit        known;
        rsp_item_t want;
    } plan_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    req_item_t req       = '0;
    logic      rsp_ready = 1'b0;
    logic      req_ready;
    logic      rsp_valid;
    rsp_item_t rsp;

    header_index_dynamic_table_core #(
        .RING_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Table shadow: ring contents, oldest position, live count, bytes
    // ---------------------------------------------------------------
    logic [HANDLE_W-1:0] tbl_handle [DEPTH];
    logic [LEN_W-1:0]    tbl_name   [DEPTH];
    logic [LEN_W-1:0]    tbl_value  [DEPTH];
    int tbl_oldest = 0;
    int tbl_live   = 0;
    int tbl_bytes  = 0;
    int tbl_limit  = int'(LIMIT_RESET);

    rsp_item_t expected_rsp [$];
    plan_row_t dir_plan [$];
    int        fail_count = 0;
    int        rsp_seen   = 0;
    int        sent_count = 0;
    int        burst_left = 0;
    int        cycle_count = 0;
    rsp_item_t oldest_want;

    function automatic void drop_oldest();
        int sz;
        if (tbl_live == 0)
            return;
        sz = tbl_name[tbl_oldest] + tbl_value[tbl_oldest] + ENTRY_OVERHEAD;
        tbl_bytes  = (sz <= tbl_bytes) ? tbl_bytes - sz : 0;
        tbl_oldest = (tbl_oldest + 1) % DEPTH;
        tbl_live--;
    endfunction

    function automatic int evict_over_limit();
        int n;
        n = 0;
        while (tbl_live > 0 && tbl_bytes > tbl_limit) begin
            drop_oldest();
            n++;
        end
        return n;
    endfunction

    function automatic rsp_item_t table_apply(input req_item_t it);
        rsp_item_t r;
        int        sz;
        int        evicted;
        int        idx;
        int        pos;
        r = '0;
        evicted = 0;
        case (it.func)
            FUNC_ADD: begin
                sz = it.name_len + it.value_len + ENTRY_OVERHEAD;
                if (sz > tbl_limit) begin
                    // oversized entry empties the table and is not stored
                    while (tbl_live > 0) begin
                        drop_oldest();
                        evicted++;
                    end
                    tbl_bytes = 0;
                end else begin
                    if (tbl_live >= DEPTH) begin
                        drop_oldest();
                        evicted++;
                    end
                    pos = (tbl_oldest + tbl_live) % DEPTH;
                    tbl_handle[pos] = it.entry_handle;
                    tbl_name[pos]   = it.name_len;
                    tbl_value[pos]  = it.value_len;
                    tbl_live++;
                    tbl_bytes += sz;
                    evicted += evict_over_limit();
                end
            end
            FUNC_LOOKUP: begin
                idx = it.lookup_index;
                if (idx >= 1 && idx <= STATIC_COUNT) begin
                    r.status      = STATUS_STATIC_HIT;
                    r.static_slot = SLOT_W'(idx);
                end else if (idx > STATIC_COUNT && idx - STATIC_COUNT <= tbl_live) begin
                    // newest entry sits right after the static slots
                    pos = (tbl_oldest + tbl_live - 1 - (idx - STATIC_COUNT - 1)) % DEPTH;
                    r.status          = STATUS_DYN_HIT;
                    r.found_handle    = tbl_handle[pos];
                    r.found_name_len  = tbl_name[pos];
                    r.found_value_len = tbl_value[pos];
                end else begin
                    r.status = STATUS_MISS;
                end
            end
            FUNC_RESIZE: begin
                tbl_limit = it.new_limit;
                evicted = evict_over_limit();
            end
            default: r.status = STATUS_MISS;
        endcase
        r.bytes_in_use   = LIMIT_W'(tbl_bytes);
        r.entries_in_use = COUNT_W'(tbl_live);
        r.evicted_count  = COUNT_W'(evicted);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Item builders
    // ---------------------------------------------------------------
    function automatic req_item_t mk_req(input logic [1:0] func, input int handle,
                                         input int nlen, input int vlen,
                                         input int idx, input int lim);
        req_item_t it;
        it.func         = func;
        it.entry_handle = HANDLE_W'(handle);
        it.name_len     = LEN_W'(nlen);
        it.value_len    = LEN_W'(vlen);
        it.lookup_index = INDEX_W'(idx);
        it.new_limit    = LIMIT_W'(lim);
        return it;
    endfunction

    function automatic rsp_item_t mk_rsp(input logic [1:0] status, input int slot,
                                         input int fh, input int fn, input int fv,
                                         input int bytes, input int ents, input int ev);
        rsp_item_t r;
        r.status          = status;
        r.static_slot     = SLOT_W'(slot);
        r.found_handle    = HANDLE_W'(fh);
        r.found_name_len  = LEN_W'(fn);
        r.found_value_len = LEN_W'(fv);
        r.bytes_in_use    = LIMIT_W'(bytes);
        r.entries_in_use  = COUNT_W'(ents);
        r.evicted_count   = COUNT_W'(ev);
        return r;
    endfunction

    function automatic void plan_add(input req_item_t it, input bit known, input rsp_item_t want);
        plan_row_t row;
        row.item  = it;
        row.known = known;
        row.want  = want;
        dir_plan.insert(dir_plan.size(), row);
    endfunction

    function automatic req_item_t next_req(input gen_flavor_t flavor);
        req_item_t    it;
        logic [95:0]  noise;
        int           pick;
        int           sub;
        noise = {$urandom(), $urandom(), $urandom()};
        it = noise[$bits(req_item_t)-1:0];
        if (flavor == GEN_NOISE)
            return it;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        if (flavor == GEN_FILL) begin
            if (pick < 85) begin
                it.func      = FUNC_ADD;
                it.name_len  = LEN_W'($urandom_range(0, 20));
                it.value_len = LEN_W'($urandom_range(0, 20));
            end else begin
                it.func         = FUNC_LOOKUP;
                it.lookup_index = INDEX_W'(STATIC_COUNT + 1 + $urandom_range(0, tbl_live));
            end
            return it;
        end
        if (pick < 45) begin
            it.func = FUNC_ADD;
            if (sub < 8) begin
                it.name_len  = LEN_W'($urandom_range(0, 300));
                it.value_len = LEN_W'($urandom_range(0, 300));
            end
        end else if (pick < 80) begin
            it.func = FUNC_LOOKUP;
            // one past the oldest live entry lands on a miss
            if (sub < 5)
                it.lookup_index = INDEX_W'(STATIC_COUNT + 1 + $urandom_range(0, tbl_live));
            else if (sub < 7)
                it.lookup_index = INDEX_W'($urandom_range(1, STATIC_COUNT));
        end else if (pick < 96) begin
            it.func = FUNC_RESIZE;
            if (sub < 6)
                it.new_limit = LIMIT_W'($urandom_range(2000, 65535));
            else if (sub < 8)
                it.new_limit = LIMIT_W'($urandom_range(0, 400));
        end else begin
            it.func = FUNC_UNKNOWN;
        end
        return it;
    endfunction

    function automatic req_item_t resize_to(input int lim);
        req_item_t it;
        it = next_req(GEN_NOISE);
        it.func      = FUNC_RESIZE;
        it.new_limit = LIMIT_W'(lim);
        return it;
    endfunction

    function automatic string fmt_rsp(input rsp_item_t r);
        return $sformatf("st=%0d slot=%0d h=%h n=%0d v=%0d bytes=%0d ent=%0d ev=%0d",
                         r.status, r.static_slot, r.found_handle, r.found_name_len,
                         r.found_value_len, r.bytes_in_use, r.entries_in_use,
                         r.evicted_count);
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of items with random gaps
    // ---------------------------------------------------------------
    task automatic send_item(input req_item_t it, input bit known, input rsp_item_t want);
        rsp_item_t pred;
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        pred = table_apply(it);
        expected_rsp.insert(expected_rsp.size(), known ? want : pred);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stalls: always ready, random, or a rotating pattern
    // ---------------------------------------------------------------
    int           hold_left = 0;
    int           hold_mode = 0;
    logic [15:0]  hold_pat  = 16'hB3E5;

    always @(posedge clk) begin
        if (hold_left == 0) begin
            hold_mode <= $urandom_range(0, 2);
            hold_left <= $urandom_range(40, 250);
            hold_pat  <= 16'($urandom()) | 16'h0001;
            rsp_ready <= 1'b1;
        end else begin
            hold_left <= hold_left - 1;
            if (hold_mode == 0) begin
                rsp_ready <= 1'b1;
            end else if (hold_mode == 1) begin
                rsp_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                rsp_ready <= hold_pat[0];
                hold_pat  <= {hold_pat[0], hold_pat[15:1]};
            end
        end
    end

    // ---------------------------------------------------------------
    // Response checker
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("response %0d with nothing pending: %s", rsp_seen, fmt_rsp(rsp));
            end else begin
                oldest_want = expected_rsp.pop_front();
                if (rsp.status !== oldest_want.status
                    || rsp.static_slot !== oldest_want.static_slot
                    || rsp.found_handle !== oldest_want.found_handle
                    || rsp.found_name_len !== oldest_want.found_name_len
                    || rsp.found_value_len !== oldest_want.found_value_len
                    || rsp.bytes_in_use !== oldest_want.bytes_in_use
                    || rsp.entries_in_use !== oldest_want.entries_in_use
                    || rsp.evicted_count !== oldest_want.evicted_count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("response %0d mismatch: exp %s / got %s",
                                 rsp_seen, fmt_rsp(oldest_want), fmt_rsp(rsp));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: static range, dynamic range misses, bad func
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, 1, 0), 1,
                 mk_rsp(STATUS_STATIC_HIT, 1, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT, 0), 1,
                 mk_rsp(STATUS_STATIC_HIT, STATIC_COUNT, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 1, 0), 1,
                 mk_rsp(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, 127, 0), 1,
                 mk_rsp(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_UNKNOWN, 0, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        // entry bigger than the reset limit is dropped
        plan_add(mk_req(FUNC_ADD, 16'hFFFF, 4095, 4095, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_ADD, 0, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 32, 1, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 1, 0), 1,
                 mk_rsp(STATUS_DYN_HIT, 0, 0, 0, 0, 32, 1, 0));
        plan_add(mk_req(FUNC_ADD, 16'hA5A5, 100, 200, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 364, 2, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 1, 0), 1,
                 mk_rsp(STATUS_DYN_HIT, 0, 16'hA5A5, 100, 200, 364, 2, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 2, 0), 1,
                 mk_rsp(STATUS_DYN_HIT, 0, 0, 0, 0, 364, 2, 0));
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 3, 0), 1,
                 mk_rsp(STATUS_MISS, 0, 0, 0, 0, 364, 2, 0));
        // fills to exactly the limit, then one more pushes out the oldest
        plan_add(mk_req(FUNC_ADD, 16'h5A5A, 2000, 1700, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 4096, 3, 0));
        plan_add(mk_req(FUNC_ADD, 16'h1234, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 4096, 3, 1));
        // oversized entry with live entries empties the table
        plan_add(mk_req(FUNC_ADD, 16'h4321, 4000, 4000, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 3));
        plan_add(mk_req(FUNC_RESIZE, 0, 0, 0, 0, 65535), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_ADD, 16'hFFFF, 4095, 4095, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 8222, 1, 0));
        plan_add(mk_req(FUNC_ADD, 16'h0001, 10, 20, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 8284, 2, 0));
        plan_add(mk_req(FUNC_RESIZE, 0, 0, 0, 0, 62), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 62, 1, 1));
        plan_add(mk_req(FUNC_RESIZE, 0, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 1));
        plan_add(mk_req(FUNC_ADD, 0, 0, 0, 0, 0), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_RESIZE, 0, 0, 0, 0, 4096), 1,
                 mk_rsp(STATUS_DONE, 0, 0, 0, 0, 0, 0, 0));
        plan_add(mk_req(FUNC_ADD, 16'h7E57, 300, 44, 0, 0), 0, '0);
        plan_add(mk_req(FUNC_LOOKUP, 0, 0, 0, STATIC_COUNT + 1, 0), 0, '0);

        foreach (dir_plan[i])
            send_item(dir_plan[i].item, dir_plan[i].known, dir_plan[i].want);

        while (sent_count < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // open the limit and pack the ring until it wraps
                    send_item(resize_to($urandom_range(20000, 65535)), 1'b0, '0);
                    n = $urandom_range(70, 90);
                    repeat (n) send_item(next_req(GEN_FILL), 1'b0, '0);
                    if ($urandom_range(0, 1) == 1)
                        send_item(resize_to($urandom_range(0, 3000)), 1'b0, '0);
                end
                9: begin
                    repeat (10) send_item(next_req(GEN_NOISE), 1'b0, '0);
                end
                default: begin
                    n = $urandom_range(20, 60);
                    repeat (n) send_item(next_req(GEN_CHURN), 1'b0, '0);
                end
            endcase
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hidt_pkg.sv
hw/rtl/hidt_ram.sv
hw/rtl/hidt_ctrl.sv
hw/rtl/hidt_dpath.sv
hw/rtl/header_index_dynamic_table_core.sv
sim/header_index_dynamic_table_core_tb.sv
